FILE: sv/iir_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iir_pkg
// Shared widths, register indexes and types for the direct-form-I IIR filter.
// ----------------------------------------------------------------------------
package iir_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 24;
  localparam int FRAC_BITS = 20;
  localparam int PROD_W    = SAMPLE_W + COEF_W;
  localparam int FF_SUM_W  = PROD_W + 2;
  localparam int ACC_W     = PROD_W + 4;
  localparam int SHIFT_W   = ACC_W - FRAC_BITS;
  localparam int ORDER_W   = 2;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_FILTER_ORDER = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_FF_COEF_0    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_FF_COEF_1    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_FF_COEF_2    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_FB_COEF_1    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_FB_COEF_2    = 3'd5;

  localparam logic [ORDER_W-1:0] ORDER_RESET = 2'd2;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [FF_SUM_W-1:0] ff_sum_t;

  typedef struct packed {
    sample_t filtered;
    logic    last;
    logic    overflow;
  } result_t;

endpackage

FILE: sv/iir_tap_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iir_tap_cell
// One feedforward tap: holds a delayed sample, passes it on to the next cell
// and registers the product of its input sample and coefficient.
// ----------------------------------------------------------------------------
module iir_tap_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  iir_pkg::coef_t         coef_i,
  input  iir_pkg::sample_t       sample_i,
  output iir_pkg::sample_t       sample_o,
  output iir_pkg::prod_t         prod_o
);
  import iir_pkg::*;

  sample_t hist_q;
  prod_t   prod_q;
  prod_t   prod_d;

  assign prod_d = coef_i * sample_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
    end else if (en_i) begin
      hist_q <= sample_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign sample_o = hist_q;
  assign prod_o   = prod_q;

endmodule

FILE: sv/iir_fb_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iir_fb_stage
// Feedback stage: adds the feedback taps to the feedforward sum, rounds,
// saturates, keeps the output history and holds the result register.
// ----------------------------------------------------------------------------
module iir_fb_stage (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  iir_pkg::ff_sum_t       ff_sum_i,
  input  logic                   last_i,
  input  iir_pkg::coef_t         fb_coef_1_i,
  input  iir_pkg::coef_t         fb_coef_2_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output iir_pkg::result_t       result_o
);
  import iir_pkg::*;

  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (FRAC_BITS - 1);

  logic                      load;
  sample_t                   y1_q, y2_q, y2_d;
  prod_t                     fb2_prod_q, fb2_prod_d, fb1_prod;
  logic signed [ACC_W-1:0]   acc;
  logic signed [SHIFT_W-1:0] shifted;
  logic                      sat_hi, sat_lo;
  result_t                   res_d, res_q;
  logic                      valid_q;

  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  // y[n-2] product is registered from the y[n-2] history as it will stand after the update
  assign y2_d       = load ? y1_q : y2_q;
  assign fb2_prod_d = fb_coef_2_i * y2_d;
  assign fb1_prod   = fb_coef_1_i * y1_q;

  assign acc = ACC_W'(ff_sum_i) + ACC_W'(fb1_prod) + ACC_W'(fb2_prod_q) + HALF;
  assign shifted = acc[ACC_W-1:FRAC_BITS];

  assign sat_hi = !shifted[SHIFT_W-1] && (shifted[SHIFT_W-2:SAMPLE_W-1] != '0);
  assign sat_lo = shifted[SHIFT_W-1] && (shifted[SHIFT_W-2:SAMPLE_W-1] != '1);

  always_comb begin
    res_d.last     = last_i;
    res_d.overflow = sat_hi || sat_lo;
    if (sat_hi) begin
      res_d.filtered = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else if (sat_lo) begin
      res_d.filtered = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      res_d.filtered = shifted[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      y1_q    <= '0;
      y2_q    <= '0;
    end else begin
      y2_q <= y2_d;
      if (load) begin
        valid_q <= 1'b1;
        y1_q    <= res_d.filtered;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fb2_prod_q <= fb2_prod_d;
    if (load) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = res_q;

endmodule

FILE: sv/iir_filter_direct_form_one.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iir_filter_direct_form_one
// Direct-form-I IIR filter of order one or two, Q3.20 coefficients, rounded
// and saturated 16-bit output that also feeds the output history.
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  s_axis   | in        | tdata[15:0] sample, tlast last
//  m_axis   | out       | tdata[15:0] filtered, tlast last_out, tuser overflow
//  cfg      | in        | cfg_index_i register index, cfg_data_i[23:0] value
//
//  One request per cycle sustained while m_axis_tready is high; the registered
//  stages are tap products, feedforward sum, feedback add and saturate.
//  The y[n-1] multiply, add, round and saturate are combinational and close the loop.
//  Reset clears both histories, coefficients to zero and order to two.
//  A stall on m_axis backs up through the stages to s_axis_tready.
// ----------------------------------------------------------------------------
module iir_filter_direct_form_one (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [iir_pkg::SAMPLE_W-1:0]     s_axis_tdata,   // [15:0] sample
  input  logic                             s_axis_tlast,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [iir_pkg::SAMPLE_W-1:0]     m_axis_tdata,   // [15:0] filtered
  output logic                             m_axis_tlast,
  output logic                             m_axis_tuser,   // [0] overflow
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [iir_pkg::REG_IDX_W-1:0]    cfg_index_i,
  input  logic [iir_pkg::COEF_W-1:0]       cfg_data_i
);
  import iir_pkg::*;

  logic [ORDER_W-1:0] order_q;
  coef_t   ff0_q, ff1_q, ff2_q, fb1_q, fb2_q;
  coef_t   ff2_eff, fb2_eff;
  logic    use_two;

  logic    s_fire, s1_ready, s1_valid_q, s1_last_q;
  logic    s2_ready, s2_load, s2_valid_q, s2_last_q;
  logic    fb_ready;
  sample_t x1, x2;
  prod_t   p0, p1, p2;
  ff_sum_t ff_sum_q;
  result_t res;

  // Configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= ORDER_RESET;
      ff0_q   <= '0;
      ff1_q   <= '0;
      ff2_q   <= '0;
      fb1_q   <= '0;
      fb2_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_FILTER_ORDER: order_q <= cfg_data_i[ORDER_W-1:0];
        REG_FF_COEF_0:    ff0_q   <= cfg_data_i;
        REG_FF_COEF_1:    ff1_q   <= cfg_data_i;
        REG_FF_COEF_2:    ff2_q   <= cfg_data_i;
        REG_FB_COEF_1:    fb1_q   <= cfg_data_i;
        REG_FB_COEF_2:    fb2_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // order 0 acts as 1, order 3 as 2
  assign use_two = order_q[1];
  assign ff2_eff = use_two ? ff2_q : '0;
  assign fb2_eff = use_two ? fb2_q : '0;

  // Pipeline control
  assign s2_ready      = !s2_valid_q || fb_ready;
  assign s1_ready      = !s1_valid_q || s2_ready;
  assign s2_load       = s1_valid_q && s2_ready;
  assign s_axis_tready = s1_ready;
  assign s_fire        = s_axis_tvalid && s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= s_axis_tvalid;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      s1_last_q <= s_axis_tlast;
    end
    if (s2_load) begin
      s2_last_q <= s1_last_q;
      ff_sum_q  <= FF_SUM_W'(p0) + FF_SUM_W'(p1) + FF_SUM_W'(p2);
    end
  end

  // Feedforward tap chain
  iir_tap_cell u_tap0 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (s_fire),
    .coef_i   (ff0_q),
    .sample_i (s_axis_tdata),
    .sample_o (x1),
    .prod_o   (p0)
  );

  iir_tap_cell u_tap1 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (s_fire),
    .coef_i   (ff1_q),
    .sample_i (x1),
    .sample_o (x2),
    .prod_o   (p1)
  );

  iir_tap_cell u_tap2 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (s_fire),
    .coef_i   (ff2_eff),
    .sample_i (x2),
    .sample_o (),
    .prod_o   (p2)
  );

  iir_fb_stage u_fb (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s2_valid_q),
    .in_ready_o  (fb_ready),
    .ff_sum_i    (ff_sum_q),
    .last_i      (s2_last_q),
    .fb_coef_1_i (fb1_q),
    .fb_coef_2_i (fb2_eff),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .result_o    (res)
  );

  assign m_axis_tdata = res.filtered;
  assign m_axis_tlast = res.last;
  assign m_axis_tuser = res.overflow;

endmodule
